### rtl/mfbd_pkg.sv
package mfbd_pkg;

    // Display geometry. The store holds one byte per column for each 8-row page.
    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;

    localparam int COL_W  = $clog2(DISPLAY_WIDTH);
    localparam int ROW_W  = $clog2(DISPLAY_HEIGHT);
    localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int ADDR_W = $clog2(STORE_BYTES);

    // Field widths of the command and result beats.
    localparam int ACTION_W   = 3;
    localparam int COORD_W    = 10;
    localparam int SIZE_W     = 9;
    localparam int RADDR_W    = 10;
    localparam int BYTE_W     = 8;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 8;

    // Extended coordinate width for rectangle edges, and the line error width.
    localparam int EXT_W = 12;
    localparam int ERR_W = 13;

    localparam logic signed [EXT_W-1:0] COL_LIMIT = EXT_W'(DISPLAY_WIDTH);
    localparam logic signed [EXT_W-1:0] ROW_LIMIT = EXT_W'(DISPLAY_HEIGHT);

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Action codes carried in tuser.
    localparam logic [ACTION_W-1:0] ACT_LINE    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_OUTLINE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FILL    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ    = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0]              op;
        logic                             ink;
        // line
        logic signed [COORD_W-1:0]        x0;
        logic signed [COORD_W-1:0]        y0;
        logic signed [COORD_W-1:0]        x1;
        logic signed [COORD_W-1:0]        y1;
        logic [COORD_W-1:0]               dx;
        logic [COORD_W-1:0]               dy;
        logic                             sx;
        logic                             sy;
        logic signed [ERR_W-1:0]          err0;
        // rectangle: bounds clipped to the display, edges as given
        logic                             empty;
        logic                             fill;
        logic [COL_W-1:0]                 c_lo;
        logic [COL_W-1:0]                 c_hi;
        logic [PAGE_W-1:0]                p_lo;
        logic [PAGE_W-1:0]                p_hi;
        logic signed [EXT_W-1:0]          r_lo;
        logic signed [EXT_W-1:0]          r_hi;
        logic signed [EXT_W-1:0]          left;
        logic signed [EXT_W-1:0]          right;
        logic signed [EXT_W-1:0]          top;
        logic signed [EXT_W-1:0]          bot;
        // read
        logic                             rd_ok;
        logic [ADDR_W-1:0]                rd_addr;
    } t_cmd;

    function automatic logic signed [EXT_W-1:0] ext_coord(input logic signed [COORD_W-1:0] v);
        return EXT_W'(v);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [PAGE_W-1:0] page,
                                                  input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(page) * ADDR_W'(DISPLAY_WIDTH);
        return base + ADDR_W'(col);
    endfunction

endpackage

### rtl/mfbd_front.sv
module mfbd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // x_start, y_start, x_end, y_end, rect_width, rect_height, ink, read_address
    input  logic [mfbd_pkg::IN_DATA_W-1:0] i_s_tdata,
    // action
    input  logic [mfbd_pkg::ACTION_W-1:0]  i_s_tuser,
    input  logic                           i_init_busy,
    output logic                           o_push,
    output mfbd_pkg::t_cmd                 o_cmd,
    input  logic                           i_full
);
    import mfbd_pkg::*;

    logic                      r_valid;
    logic                      n_valid;
    t_cmd                      r_cmd;
    t_cmd                      dec;
    logic                      accept;

    logic signed [COORD_W-1:0] xs, ys, xe, ye;
    logic [SIZE_W-1:0]         w, h;
    logic [RADDR_W-1:0]        raddr;
    logic signed [COORD_W:0]   xdiff, ydiff;
    logic signed [EXT_W-1:0]   xs_e, ys_e, xend_e, yend_e;
    logic signed [EXT_W-1:0]   xa, xb, ya, yb, xb_m1, yb_m1;

    assign xs    = $signed(i_s_tdata[9:0]);
    assign ys    = $signed(i_s_tdata[19:10]);
    assign xe    = $signed(i_s_tdata[29:20]);
    assign ye    = $signed(i_s_tdata[39:30]);
    assign w     = i_s_tdata[48:40];
    assign h     = i_s_tdata[57:49];
    assign raddr = i_s_tdata[68:59];

    always_comb begin
        dec      = '0;
        dec.op   = i_s_tuser;
        dec.ink  = i_s_tdata[58];

        // Line setup: magnitudes, directions and the initial error.
        xdiff    = (COORD_W+1)'(xe) - (COORD_W+1)'(xs);
        ydiff    = (COORD_W+1)'(ye) - (COORD_W+1)'(ys);
        dec.x0   = xs;
        dec.y0   = ys;
        dec.x1   = xe;
        dec.y1   = ye;
        dec.dx   = xdiff[COORD_W] ? COORD_W'(-xdiff) : xdiff[COORD_W-1:0];
        dec.dy   = ydiff[COORD_W] ? COORD_W'(-ydiff) : ydiff[COORD_W-1:0];
        dec.sx   = xs < xe;
        dec.sy   = ys < ye;
        dec.err0 = $signed(ERR_W'(dec.dx)) - $signed(ERR_W'(dec.dy));

        // Rectangle setup: clip to the display once, here.
        xs_e     = ext_coord(xs);
        ys_e     = ext_coord(ys);
        xend_e   = xs_e + $signed(EXT_W'(w));
        yend_e   = ys_e + $signed(EXT_W'(h));
        xa       = (xs_e < 0) ? '0 : xs_e;
        ya       = (ys_e < 0) ? '0 : ys_e;
        xb       = (xend_e > COL_LIMIT) ? COL_LIMIT : xend_e;
        yb       = (yend_e > ROW_LIMIT) ? ROW_LIMIT : yend_e;
        xb_m1    = xb - EXT_W'(1);
        yb_m1    = yb - EXT_W'(1);
        dec.empty = (w == '0) || (h == '0) || (xa >= xb) || (ya >= yb);
        dec.fill  = (i_s_tuser == ACT_FILL);
        dec.c_lo  = COL_W'(xa);
        dec.c_hi  = COL_W'(xb_m1);
        dec.p_lo  = PAGE_W'(xa[EXT_W-1] ? '0 : ya[EXT_W-1:3]);
        dec.p_hi  = PAGE_W'(yb_m1[EXT_W-1:3]);
        dec.r_lo  = ya;
        dec.r_hi  = yb_m1;
        dec.left  = xs_e;
        dec.right = xend_e - EXT_W'(1);
        dec.top   = ys_e;
        dec.bot   = yend_e - EXT_W'(1);

        dec.rd_ok   = (EXT_W+1)'(raddr) < (EXT_W+1)'(STORE_BYTES);
        dec.rd_addr = ADDR_W'(raddr);
    end

    assign o_s_tready = !i_init_busy && (!r_valid || !i_full);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_push     = r_valid && !i_full;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_valid = accept || (r_valid && !o_push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_cmd <= dec;
        end
    end

endmodule

### rtl/mfbd_queue.sv
module mfbd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mfbd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mfbd_pkg::t_cmd o_cmd
);
    import mfbd_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QPTR_W:0]   r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

### rtl/mfbd_back.sv
module mfbd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    input  mfbd_pkg::t_cmd                  i_q_cmd,
    output logic                            o_q_pop,
    output logic                            o_init_busy,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // read_data
    output logic [mfbd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // was_read
    output logic                            o_m_tuser
);
    import mfbd_pkg::*;

    localparam logic [3:0] S_WIPE   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LINE   = 4'd2;
    localparam logic [3:0] S_LWR    = 4'd3;
    localparam logic [3:0] S_RECT   = 4'd4;
    localparam logic [3:0] S_RWR    = 4'd5;
    localparam logic [3:0] S_READ   = 4'd6;
    localparam logic [3:0] S_RESULT = 4'd7;

    logic [3:0]                r_state, n_state;
    logic                      r_init, n_init;
    logic [ADDR_W-1:0]         r_wipe, n_wipe;
    t_cmd                      r_cmd, n_cmd;
    logic signed [COORD_W-1:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic [COL_W-1:0]          r_col, n_col;
    logic [PAGE_W-1:0]         r_page, n_page;
    logic                      r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]         r_out_data, n_out_data;
    logic                      r_out_read, n_out_read;

    // Frame store, one write and one registered read per cycle.
    logic [BYTE_W-1:0]         r_mem [STORE_BYTES];
    logic [BYTE_W-1:0]         r_mem_q;
    logic                      mem_we, mem_re;
    logic [ADDR_W-1:0]         mem_waddr, mem_raddr;
    logic [BYTE_W-1:0]         mem_wdata;

    // Line walker view of the current pixel.
    logic                      l_on;
    logic                      l_end;
    logic [ROW_W-1:0]          l_row;
    logic [ADDR_W-1:0]         l_addr;
    logic [BYTE_W-1:0]         l_mask;
    logic signed [EXT_W-1:0]   cx_e, cy_e;
    logic signed [ERR_W-1:0]   e2, dx_e, dy_neg, err_a;
    logic                      step_x, step_y;

    // Rectangle view of the current byte.
    logic [ADDR_W-1:0]         r_addr_cur;
    logic [BYTE_W-1:0]         r_mask;
    logic                      r_last;
    logic signed [EXT_W-1:0]   col_e, row_e;
    logic                      edge_col;

    always_comb begin
        cx_e   = ext_coord(r_cx);
        cy_e   = ext_coord(r_cy);
        l_on   = (cx_e >= 0) && (cx_e < COL_LIMIT) && (cy_e >= 0) && (cy_e < ROW_LIMIT);
        l_end  = (r_cx == r_cmd.x1) && (r_cy == r_cmd.y1);
        l_row  = ROW_W'(r_cy);
        l_addr = addr_of(PAGE_W'(l_row >> 3), COL_W'(r_cx));
        l_mask = BYTE_W'(1) << l_row[2:0];

        dx_e   = $signed(ERR_W'(r_cmd.dx));
        dy_neg = -$signed(ERR_W'(r_cmd.dy));
        e2     = r_err <<< 1;
        step_x = e2 >= dy_neg;
        step_y = e2 <= dx_e;
        err_a  = step_x ? r_err + dy_neg : r_err;
    end

    always_comb begin
        col_e      = $signed(EXT_W'(r_col));
        edge_col   = (col_e == r_cmd.left) || (col_e == r_cmd.right);
        r_addr_cur = addr_of(r_page, r_col);
        r_last     = (r_page == r_cmd.p_hi) && (r_col == r_cmd.c_hi);
        r_mask     = '0;
        row_e      = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            row_e     = $signed(EXT_W'({r_page, 3'b000})) + EXT_W'(k);
            r_mask[k] = (row_e >= r_cmd.r_lo) && (row_e <= r_cmd.r_hi) &&
                        (r_cmd.fill || edge_col || (row_e == r_cmd.top) ||
                         (row_e == r_cmd.bot));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_wipe      = r_wipe;
        n_cmd       = r_cmd;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_err       = r_err;
        n_col       = r_col;
        n_page      = r_page;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_read  = r_out_read;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = l_addr;
        mem_raddr   = l_addr;
        mem_wdata   = '0;

        case (r_state)
            S_WIPE: begin
                mem_we    = 1'b1;
                mem_waddr = r_wipe;
                mem_wdata = '0;
                if (r_wipe == ADDR_W'(STORE_BYTES - 1)) begin
                    n_state = r_init ? S_IDLE : S_RESULT;
                    n_init  = 1'b0;
                end else begin
                    n_wipe = r_wipe + 1'b1;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    case (i_q_cmd.op)
                        ACT_LINE: begin
                            n_cx    = i_q_cmd.x0;
                            n_cy    = i_q_cmd.y0;
                            n_err   = i_q_cmd.err0;
                            n_state = S_LINE;
                        end
                        ACT_OUTLINE, ACT_FILL: begin
                            n_col   = i_q_cmd.c_lo;
                            n_page  = i_q_cmd.p_lo;
                            n_state = i_q_cmd.empty ? S_RESULT : S_RECT;
                        end
                        ACT_CLEAR: begin
                            n_wipe  = '0;
                            n_state = S_WIPE;
                        end
                        ACT_READ: begin
                            n_state = i_q_cmd.rd_ok ? S_READ : S_RESULT;
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_LINE, S_LWR: begin
                // S_LINE fetches the byte under an on-screen cursor; S_LWR writes it
                // back. Off-screen pixels advance without touching the store.
                if (r_state == S_LINE && l_on) begin
                    mem_re  = 1'b1;
                    n_state = S_LWR;
                end else begin
                    if (r_state == S_LWR) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_cmd.ink ? (r_mem_q | l_mask) : (r_mem_q & ~l_mask);
                    end
                    if (l_end) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_LINE;
                        n_err   = step_y ? err_a + dx_e : err_a;
                        if (step_x) begin
                            n_cx = r_cmd.sx ? r_cx + COORD_W'(1) : r_cx - COORD_W'(1);
                        end
                        if (step_y) begin
                            n_cy = r_cmd.sy ? r_cy + COORD_W'(1) : r_cy - COORD_W'(1);
                        end
                    end
                end
            end
            S_RECT, S_RWR: begin
                mem_waddr = r_addr_cur;
                mem_raddr = r_addr_cur;
                if (r_state == S_RECT && r_mask != '0) begin
                    mem_re  = 1'b1;
                    n_state = S_RWR;
                end else begin
                    if (r_state == S_RWR) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_cmd.ink ? (r_mem_q | r_mask) : (r_mem_q & ~r_mask);
                    end
                    if (r_last) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_RECT;
                        if (r_page == r_cmd.p_hi) begin
                            n_page = r_cmd.p_lo;
                            n_col  = r_col + 1'b1;
                        end else begin
                            n_page = r_page + 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                mem_re    = 1'b1;
                mem_raddr = r_cmd.rd_addr;
                n_state   = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_read  = (r_cmd.op == ACT_READ);
                    n_out_data  = (r_cmd.op == ACT_READ && r_cmd.rd_ok) ? r_mem_q : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WIPE;
            r_init      <= 1'b1;
            r_wipe      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_wipe      <= n_wipe;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_err      <= n_err;
        r_col      <= n_col;
        r_page     <= n_page;
        r_out_data <= n_out_data;
        r_out_read <= n_out_read;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

    assign o_init_busy = r_init;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_read;

endmodule

### rtl/mono_framebuffer_line_rect_drawer_core.sv
// Drawing engine over a paged monochrome framebuffer (one byte per column per
// 8-row page). Commands arrive as beats on the s-side stream: tuser carries the
// action (line, outline, fill, clear, read) and tdata the coordinates, sizes,
// ink and read address. Every command yields exactly one result beat on the
// m-side stream: tdata is the stored byte for a read and zero otherwise, and
// tuser flags a read.
// A front stage decodes and clips each command and places it in a two-entry
// queue, so the next command is taken while the back end still draws.
// The back end takes each command from the queue, draws it and then posts its
// result. A line walks every pixel of its path and a rectangle every byte of
// its clipped box; a byte that gets a pixel is read and then written back,
// while off-screen pixels and other bytes are only stepped over. A clear wipes
// the whole store and a read fetches one byte. Each command passes the front
// register and the queue before the back end takes it, and the back end takes
// the next command only once the result of the last one is posted.
// After reset the store is wiped, one byte a cycle over all STORE_BYTES (1024)
// bytes, and s_tready stays low until it is done.
// The result sits in an output register; if the receiver stalls, the back
// end holds its next result and the front queues commands while there is room.
module mono_framebuffer_line_rect_drawer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // x_start[9:0], y_start[19:10], x_end[29:20], y_end[39:30],
    // rect_width[48:40], rect_height[57:49], ink[58], read_address[68:59], zero[71:69]
    input  logic [mfbd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // action[2:0]
    input  logic [mfbd_pkg::ACTION_W-1:0]   i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // read_data[7:0]
    output logic [mfbd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // was_read[0]
    output logic                            o_m_tuser
);
    import mfbd_pkg::*;

    logic push, full, pop, empty, init_busy;
    t_cmd front_cmd, head_cmd;

    mfbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_init_busy (init_busy),
        .o_push      (push),
        .o_cmd       (front_cmd),
        .i_full      (full)
    );

    mfbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    mfbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (empty),
        .i_q_cmd     (head_cmd),
        .o_q_pop     (pop),
        .o_init_busy (init_busy),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

### tb/tb_mono_framebuffer_line_rect_drawer_core.sv
module tb_mono_framebuffer_line_rect_drawer_core;
    import mfbd_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_MAX    = 10;
    localparam int PAGE_ROWS     = 8;

    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        logic [ACTION_W-1:0]       act;
        logic signed [COORD_W-1:0] xs, ys, xe, ye;
        logic [SIZE_W-1:0]         w, h;
        logic                      ink;
        logic [RADDR_W-1:0]        raddr;
    } t_draw_cmd;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              was_read;
    } t_reply;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [ACTION_W-1:0]   s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    t_draw_cmd queued_cmds[$];
    t_draw_cmd offered_cmd;
    t_reply    pending_replies[$];

    // Shadow copy of the page store and the line walker.
    logic [BYTE_W-1:0] shadow_frame [STORE_BYTES] = '{default: '0};
    int walk_x, walk_y, walk_err;

    int tx_idle_pct = 9;
    int rx_idle_pct = 79;
    int mismatches = 0;
    int replies_checked = 0;
    int nonzero_reads = 0;
    int quiet_cycles = 0;
    int act_seen [2**ACTION_W] = '{default: 0};

    mono_framebuffer_line_rect_drawer_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void put_pixel(int x, int y, logic ink);
        int idx;
        if (x < 0 || x >= DISPLAY_WIDTH || y < 0 || y >= DISPLAY_HEIGHT) return;
        idx = (y / PAGE_ROWS) * DISPLAY_WIDTH + x;
        shadow_frame[idx][y % PAGE_ROWS] = ink;
    endfunction

    function automatic void trace_line(int x0, int y0, int x1, int y1, logic ink);
        int dx, dy, sx, sy, e2;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        // The vertical distance is kept negative, as the walk expects.
        dy = (y1 > y0) ? y0 - y1 : y1 - y0;
        sx = (x0 < x1) ? 1 : -1;
        sy = (y0 < y1) ? 1 : -1;
        walk_x = x0;
        walk_y = y0;
        walk_err = dx + dy;
        while (1) begin
            put_pixel(walk_x, walk_y, ink);
            if (walk_x == x1 && walk_y == y1) break;
            e2 = 2 * walk_err;
            if (e2 >= dy) begin
                walk_err += dy;
                walk_x += sx;
            end
            if (e2 <= dx) begin
                walk_err += dx;
                walk_y += sy;
            end
        end
    endfunction

    function automatic void paint_rect(int x, int y, int w, int h, logic ink, logic solid);
        int xa, xb, ya, yb;
        if (w <= 0 || h <= 0) return;
        if (solid) begin
            xa = (x < 0) ? 0 : x;
            xb = (x + w > DISPLAY_WIDTH) ? DISPLAY_WIDTH : x + w;
            ya = (y < 0) ? 0 : y;
            yb = (y + h > DISPLAY_HEIGHT) ? DISPLAY_HEIGHT : y + h;
            for (int i = xa; i < xb; i++)
                for (int j = ya; j < yb; j++)
                    put_pixel(i, j, ink);
        end else begin
            for (int i = x; i < x + w; i++) begin
                put_pixel(i, y, ink);
                put_pixel(i, y + h - 1, ink);
            end
            for (int j = y; j < y + h; j++) begin
                put_pixel(x, j, ink);
                put_pixel(x + w - 1, j, ink);
            end
        end
    endfunction

    function automatic void predict_reply(t_draw_cmd c);
        t_reply r;
        r.data = '0;
        r.was_read = 1'b0;
        case (c.act)
            ACT_LINE:    trace_line(c.xs, c.ys, c.xe, c.ye, c.ink);
            ACT_OUTLINE: paint_rect(c.xs, c.ys, c.w, c.h, c.ink, 1'b0);
            ACT_FILL:    paint_rect(c.xs, c.ys, c.w, c.h, c.ink, 1'b1);
            ACT_CLEAR:   foreach (shadow_frame[i]) shadow_frame[i] = '0;
            ACT_READ: begin
                if (c.raddr < STORE_BYTES) r.data = shadow_frame[c.raddr];
                r.was_read = 1'b1;
                if (r.data != '0) nonzero_reads++;
            end
            default: ;
        endcase
        act_seen[c.act]++;
        pending_replies.push_back(r);
    endfunction

    function automatic t_draw_cmd make_cmd(logic [ACTION_W-1:0] act, int xs, int ys,
                                           int xe, int ye, int w, int h, logic ink,
                                           int raddr);
        t_draw_cmd c;
        c.act   = act;
        c.xs    = COORD_W'(xs);
        c.ys    = COORD_W'(ys);
        c.xe    = COORD_W'(xe);
        c.ye    = COORD_W'(ye);
        c.w     = SIZE_W'(w);
        c.h     = SIZE_W'(h);
        c.ink   = ink;
        c.raddr = RADDR_W'(raddr);
        return c;
    endfunction

    // Mostly near the display, now and then anywhere in the 10-bit range.
    function automatic logic signed [COORD_W-1:0] pick_coord(int lo, int hi);
        if ($urandom_range(3) == 0) return COORD_W'($urandom);
        return COORD_W'(lo + int'($urandom_range(hi - lo)));
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(19);
        if (r == 0) return '0;
        if (r < 4) return SIZE_W'($urandom);
        return SIZE_W'($urandom_range(40, 1));
    endfunction

    function automatic t_draw_cmd rand_cmd();
        t_draw_cmd c;
        int r;
        r = $urandom_range(99);
        if (r < 30)
            c.act = ACT_LINE;
        else if (r < 45)
            c.act = ACT_OUTLINE;
        else if (r < 55)
            c.act = ACT_FILL;
        else if (r < 58)
            c.act = ACT_CLEAR;
        else if (r < 93)
            c.act = ACT_READ;
        else
            c.act = ACT_SPARE_LO + ACTION_W'($urandom_range(ACT_SPARE_HI - ACT_SPARE_LO));
        c.xs    = pick_coord(-20, DISPLAY_WIDTH + 19);
        c.ys    = pick_coord(-20, DISPLAY_HEIGHT + 19);
        c.xe    = pick_coord(-20, DISPLAY_WIDTH + 19);
        c.ye    = pick_coord(-20, DISPLAY_HEIGHT + 19);
        c.w     = pick_size();
        c.h     = pick_size();
        c.ink   = ($urandom_range(9) < 7);
        c.raddr = RADDR_W'($urandom);
        return c;
    endfunction

    function automatic void log_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("mismatch: %s", msg);
    endfunction

    task automatic drain();
        while (queued_cmds.size() != 0 || s_tvalid || pending_replies.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, int n_items);
        t_draw_cmd c;
        int counted;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        counted = 0;
        while (counted < n_items) begin
            c = rand_cmd();
            if (c.act < ACT_SPARE_LO) counted++;
            queued_cmds.push_back(c);
        end
        drain();
    endtask

    // Command driver: a new beat is offered only once the previous one is taken.
    always @(posedge i_clk) begin : drive_commands
        logic      fire;
        t_draw_cmd nxt;
        fire = s_tvalid && s_tready;
        if (fire) predict_reply(offered_cmd);
        if (!s_tvalid || fire) begin
            if (queued_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = queued_cmds.pop_front();
                offered_cmd <= nxt;
                s_tdata  <= IN_DATA_W'({nxt.raddr, nxt.ink, nxt.h, nxt.w,
                                        nxt.ye, nxt.xe, nxt.ys, nxt.xs});
                s_tuser  <= nxt.act;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                log_mismatch($sformatf("unexpected reply data %02h read %b",
                                       m_tdata, m_tuser));
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata !== want.data)
                    log_mismatch($sformatf("reply %0d read_data expected %02h got %02h",
                                           replies_checked, want.data, m_tdata));
                if (m_tuser !== want.was_read)
                    log_mismatch($sformatf("reply %0d was_read expected %b got %b",
                                           replies_checked, want.was_read, m_tuser));
            end
            replies_checked++;
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : main
        int spare;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed commands: octants, off-screen walks, degenerate and clipped boxes.
        queued_cmds.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 1'b0, 0));
        queued_cmds.push_back(make_cmd(ACT_LINE, 0, 0, 127, 63, 0, 0, 1'b1, 0));
        queued_cmds.push_back(make_cmd(ACT_LINE, 100, 63, 90, 0, 0, 0, 1'b1, 0));
        queued_cmds.push_back(make_cmd(ACT_LINE, 5, 5, 5, 5, 0, 0, 1'b1, 0));
        queued_cmds.push_back(make_cmd(ACT_LINE, 127, 10, 0, 10, 0, 0, 1'b0, 0));
        queued_cmds.push_back(make_cmd(ACT_LINE, -512, -512, 511, 511, 0, 0, 1'b1, 0));
        queued_cmds.push_back(make_cmd(ACT_LINE, 511, -512, -512, 511, 0, 0, 1'b1, 0));
        queued_cmds.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 1'b0, 0));
        queued_cmds.push_back(make_cmd(ACT_OUTLINE, 10, 10, 0, 0, 20, 15, 1'b1, 0));
        queued_cmds.push_back(make_cmd(ACT_OUTLINE, 0, 0, 0, 0, 1, 1, 1'b0, 0));
        queued_cmds.push_back(make_cmd(ACT_OUTLINE, -5, 30, 0, 0, 200, 1, 1'b1, 0));
        queued_cmds.push_back(make_cmd(ACT_OUTLINE, 60, -3, 0, 0, 1, 70, 1'b1, 0));
        queued_cmds.push_back(make_cmd(ACT_OUTLINE, 40, 40, 0, 0, 0, 5, 1'b1, 0));
        queued_cmds.push_back(make_cmd(ACT_FILL, 30, 30, 0, 0, 5, 0, 1'b1, 0));
        queued_cmds.push_back(make_cmd(ACT_FILL, -8, -8, 0, 0, 511, 511, 1'b1, 0));
        queued_cmds.push_back(make_cmd(ACT_FILL, 20, 20, 0, 0, 30, 17, 1'b0, 0));
        queued_cmds.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 1'b0, STORE_BYTES - 1));
        queued_cmds.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 1'b0,
                                       3 * DISPLAY_WIDTH + 25));
        queued_cmds.push_back(make_cmd(ACT_OUTLINE, 511, 511, 0, 0, 511, 511, 1'b1, 0));
        queued_cmds.push_back(make_cmd(ACT_SPARE_LO, -1, -1, -1, -1, 511, 511, 1'b1, 1023));
        queued_cmds.push_back(make_cmd(ACT_SPARE_HI, -1, -1, -1, -1, 511, 511, 1'b1, 1023));
        queued_cmds.push_back(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0, 0));
        queued_cmds.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 1'b0, 0));
        queued_cmds.push_back(make_cmd(ACT_LINE, 0, 63, 127, 0, 0, 0, 1'b1, 0));
        queued_cmds.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 1'b0,
                                       (PAGE_COUNT - 1) * DISPLAY_WIDTH));
        drain();

        run_phase(9, 79, 160);
        run_phase(79, 9, 160);
        run_phase(0, 0, 140);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        spare = 0;
        for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) spare += act_seen[a];
        $display({"Commands run: %0d lines, %0d outlines, %0d fills, %0d clears, ",
                  "%0d reads, %0d spare codes."},
                 act_seen[ACT_LINE], act_seen[ACT_OUTLINE], act_seen[ACT_FILL],
                 act_seen[ACT_CLEAR], act_seen[ACT_READ], spare);
        $display("Replies checked: %0d, reads that found ink in the byte: %0d, mismatches: %0d.",
                 replies_checked, nonzero_reads, mismatches);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/mfbd_pkg.sv
rtl/mfbd_front.sv
rtl/mfbd_queue.sv
rtl/mfbd_back.sv
rtl/mono_framebuffer_line_rect_drawer_core.sv
tb/tb_mono_framebuffer_line_rect_drawer_core.sv
